### hw/rtl/clock_cache_refcount_directory_assert.svh
// Assertion macros for the clock cache directory.
// Depends on nothing; define ASSERT_OFF to compile them out.
`ifndef CLOCK_CACHE_REFCOUNT_DIRECTORY_ASSERT_SVH
`define CLOCK_CACHE_REFCOUNT_DIRECTORY_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CCRD_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CCRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CCRD_ASSERT_IMPL(label, clk, rst, ante, cons, msg)
`define CCRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/ccrd_pkg.sv
// Shared types and codes of the clock cache directory.
// No dependencies.
`timescale 1ns / 1ps
package ccrd_pkg;
   localparam int KEY_W  = 64;
   localparam int VAL_W  = 64;
   localparam int SLOT_W = 5;
   localparam int CAP_W  = 6;
   localparam int OCC_W  = 6;
   localparam logic [CAP_W-1:0] CAP_RESET = 6'd32;

   localparam logic [1:0] OP_INSERT  = 2'd0;
   localparam logic [1:0] OP_LOOKUP  = 2'd1;
   localparam logic [1:0] OP_RELEASE = 2'd2;
   localparam logic [1:0] OP_TRIM    = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_ERR  = 2'd2;

   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_NOTICE = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [1:0]        status;
      logic [SLOT_W-1:0] slot_res;
      logic [VAL_W-1:0]  freed_value;
      logic              last;
   } rsp_beat_type;
endpackage

### hw/rtl/ccrd_if.sv
// Request and response channel interfaces of the clock cache directory.
// Depends on ccrd_pkg.
`timescale 1ns / 1ps
interface ccrd_req_if;
   logic                        valid;
   logic                        ready;
   logic [1:0]                  op;
   logic [ccrd_pkg::KEY_W-1:0]  key;
   logic [ccrd_pkg::VAL_W-1:0]  value;
   logic                        hold_ref;
   logic [ccrd_pkg::SLOT_W-1:0] slot;
   logic                        set_usage;
   modport source (output valid, op, key, value, hold_ref, slot, set_usage, input ready);
   modport sink (input valid, op, key, value, hold_ref, slot, set_usage, output ready);
endinterface

interface ccrd_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [1:0]                  status;
   logic [ccrd_pkg::SLOT_W-1:0] slot_res;
   logic [ccrd_pkg::VAL_W-1:0]  freed_value;
   logic                        last;
   modport source (output valid, kind, status, slot_res, freed_value, last, input ready);
   modport sink (input valid, kind, status, slot_res, freed_value, last, output ready);
endinterface

### hw/rtl/clock_cache_refcount_directory.sv
// Clock (second-chance) cache directory, top level.
// Depends on ccrd_pkg, ccrd_if, ccrd_kv_mem, ccrd_rsp_reg and the assert header.
//
// Usage:
//  - req_ch carries one operation per beat: insert, lookup, release or trim.
//    A beat is taken when valid and ready are high; ready is high only while
//    the sequencer is idle, so one operation is in flight at a time. The next
//    beat can be taken the cycle after the final answer enters the output reg.
//  - rsp_ch returns zero or more freed-value notices (kind 1) followed by one
//    final answer (kind 0, last 1).
//  - csr_we/csr_wdata write the capacity register; write only while idle.
//  - Release answers directly; when it frees the slot it sends a freed-value
//    notice first. Lookup scans the key memory one slot per cycle over the
//    created slots. Insert runs the clock-hand sweep, with one notice per
//    eviction, then a key scan to detach an older entry with the same key.
//    Trim costs the sweep alone.
//  - The single read port of the key/value memory sets the scan rate.
//  - Reset clears all control state, the per-slot flags and counts, and sets
//    capacity to 32. Key/value memory and free stack are not cleared.
//  - A stalled receiver holds the sequencer in its emit state; nothing is lost.
`timescale 1ns / 1ps
`include "clock_cache_refcount_directory_assert.svh"
module clock_cache_refcount_directory #(
   parameter int ENTRIES  = 32,
   parameter int REF_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [ccrd_pkg::CAP_W-1:0] csr_wdata,
   ccrd_req_if.sink                   req_ch,
   ccrd_rsp_if.source                 rsp_ch
);
   import ccrd_pkg::*;

   localparam int SW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CW = $clog2(ENTRIES + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DISPATCH, S_SWEEP, S_ALLOC, S_SCAN, S_NOTICE, S_ANSWER
   } state_type;

   state_type state_ff, state_in, ret_ff, ret_in;

   // latched request
   logic [1:0]        op_ff;
   logic [KEY_W-1:0]  key_ff;
   logic [VAL_W-1:0]  value_ff;
   logic              hold_ff, set_usage_ff;
   logic [SLOT_W-1:0] rel_slot_ff;

   // per-slot flags and counts
   logic                in_cache_ff [ENTRIES];
   logic                in_cache_in [ENTRIES];
   logic                used_ff [ENTRIES];
   logic                used_in [ENTRIES];
   logic [REF_BITS-1:0] refs_ff [ENTRIES];
   logic [REF_BITS-1:0] refs_in [ENTRIES];
   logic [SW-1:0]       fstack_ff [ENTRIES];
   logic [SW-1:0]       fstack_in [ENTRIES];

   logic [CW-1:0]    created_ff, created_in, fdepth_ff, fdepth_in;
   logic [SW-1:0]    hand_ff, hand_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [CAP_W-1:0] cap_ff, cap_in;

   // sweep and scan working registers
   logic [SW-1:0]     start_ff, start_in, pos_ff, pos_in;
   logic              second_ff, second_in;
   logic [CW-1:0]     rd_idx_ff, rd_idx_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [SW-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [SW-1:0]     new_slot_ff, new_slot_in;
   logic [1:0]        status_ff, status_in;
   logic [SLOT_W-1:0] slot_res_ff, slot_res_in;

   // memory and output side
   logic             mem_we, mem_re;
   logic [SW-1:0]    mem_waddr, mem_raddr;
   logic [KEY_W-1:0] mem_rkey;
   logic [VAL_W-1:0] mem_rvalue;
   logic             rsp_push, buf_free;
   rsp_beat_type     rsp_beat;

   // combinational helpers
   logic          fin, fin_ok, evict, hit, rel_ok, freeing;
   logic [SW-1:0] rs, next_pos, s_pick;
   logic [CW:0]   pos_inc;

   assign req_ch.ready = (state_ff == S_IDLE);

   ccrd_kv_mem #(.ENTRIES(ENTRIES), .SW(SW)) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wkey  (key_ff),
      .wvalue(value_ff),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rkey  (mem_rkey),
      .rvalue(mem_rvalue)
   );

   ccrd_rsp_reg u_rsp (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .beat    (rsp_beat),
      .can_take(buf_free),
      .rsp_ch  (rsp_ch)
   );

   assign pos_inc  = (CW + 1)'(pos_ff) + (CW + 1)'(1);
   assign next_pos = (pos_inc >= {1'b0, created_ff}) ? '0 : pos_inc[SW-1:0];
   assign evict    = in_cache_ff[pos_ff] && !used_ff[pos_ff] && (refs_ff[pos_ff] == '0);
   assign rs       = SW'(rel_slot_ff);
   assign rel_ok   = ((7'(rel_slot_ff)) < 7'(ENTRIES)) && (refs_ff[rs] != '0);
   // key scan compare on the registered memory read
   assign hit = cmp_vld_ff && in_cache_ff[cmp_idx_ff] && (mem_rkey == key_ff) &&
                !(op_ff == OP_INSERT && cmp_idx_ff == new_slot_ff);

   always_comb begin
      state_in    = state_ff;
      ret_in      = ret_ff;
      in_cache_in = in_cache_ff;
      used_in     = used_ff;
      refs_in     = refs_ff;
      fstack_in   = fstack_ff;
      created_in  = created_ff;
      fdepth_in   = fdepth_ff;
      hand_in     = hand_ff;
      occ_in      = occ_ff;
      cap_in      = csr_we ? csr_wdata : cap_ff;
      start_in    = start_ff;
      pos_in      = pos_ff;
      second_in   = second_ff;
      rd_idx_in   = rd_idx_ff;
      cmp_vld_in  = cmp_vld_ff;
      cmp_idx_in  = cmp_idx_ff;
      new_slot_in = new_slot_ff;
      status_in   = status_ff;
      slot_res_in = slot_res_ff;
      mem_we      = 1'b0;
      mem_waddr   = '0;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      rsp_push    = 1'b0;
      rsp_beat    = '0;
      fin         = 1'b0;
      fin_ok      = 1'b0;
      freeing     = 1'b0;
      s_pick      = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            slot_res_in = '0;
            case (op_ff)
               OP_INSERT, OP_TRIM: begin
                  if (occ_ff == '0 || created_ff == '0) begin
                     fin    = 1'b1;
                     fin_ok = 1'b1;
                  end else begin
                     start_in  = ((CW)'(hand_ff) < created_ff) ? hand_ff : '0;
                     pos_in    = ((CW)'(hand_ff) < created_ff) ? hand_ff : '0;
                     second_in = 1'b0;
                     state_in  = S_SWEEP;
                  end
               end
               OP_LOOKUP: begin
                  rd_idx_in  = '0;
                  cmp_vld_in = 1'b0;
                  state_in   = S_SCAN;
               end
               default: begin
                  // release
                  if (!rel_ok) begin
                     status_in = ST_ERR;
                     state_in  = S_ANSWER;
                  end else begin
                     if (set_usage_ff) used_in[rs] = 1'b1;
                     refs_in[rs] = refs_ff[rs] - 1'b1;
                     status_in   = ST_OK;
                     state_in    = S_ANSWER;
                     if (refs_ff[rs] == REF_BITS'(1) && !in_cache_ff[rs]) begin
                        freeing   = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = rs;
                        if (occ_ff != '0) occ_in = occ_ff - 1'b1;
                        ret_in    = S_ANSWER;
                        state_in  = S_NOTICE;
                     end
                  end
               end
            endcase
         end
         S_SWEEP: begin
            if (7'(occ_ff) < 7'(cap_ff)) begin
               hand_in = pos_ff;
               fin     = 1'b1;
               fin_ok  = 1'b1;
            end else if (evict) begin
               in_cache_in[pos_ff] = 1'b0;
               freeing   = 1'b1;
               mem_re    = 1'b1;
               mem_raddr = pos_ff;
               if (occ_ff != '0) occ_in = occ_ff - 1'b1;
               pos_in    = next_pos;
               ret_in    = S_SWEEP;
               state_in  = S_NOTICE;
            end else begin
               used_in[pos_ff] = 1'b0;
               pos_in = next_pos;
               if (next_pos == start_ff) begin
                  if (second_ff) begin
                     fin = 1'b1;
                  end else begin
                     second_in = 1'b1;
                  end
               end
            end
         end
         S_ALLOC: begin
            if (fdepth_ff != '0 || created_ff < CW'(ENTRIES)) begin
               if (fdepth_ff != '0) begin
                  s_pick    = fstack_ff[SW'(fdepth_ff - 1'b1)];
                  fdepth_in = fdepth_ff - 1'b1;
               end else begin
                  s_pick     = SW'(created_ff);
                  created_in = created_ff + 1'b1;
               end
               mem_we              = 1'b1;
               mem_waddr           = s_pick;
               in_cache_in[s_pick] = 1'b1;
               used_in[s_pick]     = 1'b0;
               refs_in[s_pick]     = REF_BITS'(hold_ff);
               new_slot_in         = s_pick;
               status_in           = ST_OK;
               slot_res_in         = SLOT_W'(s_pick);
               rd_idx_in           = '0;
               cmp_vld_in          = 1'b0;
               state_in            = S_SCAN;
            end else begin
               status_in = ST_MISS;
               state_in  = S_ANSWER;
            end
         end
         S_SCAN: begin
            if (hit || rd_idx_ff >= created_ff) begin
               cmp_vld_in = 1'b0;
               state_in   = S_ANSWER;
               if (op_ff == OP_INSERT) begin
                  if (hit) begin
                     in_cache_in[cmp_idx_ff] = 1'b0;
                     if (refs_ff[cmp_idx_ff] == '0) begin
                        freeing   = 1'b1;
                        mem_re    = 1'b1;
                        mem_raddr = cmp_idx_ff;
                        ret_in    = S_ANSWER;
                        state_in  = S_NOTICE;
                     end
                  end
                  occ_in = occ_ff - OCC_W'(freeing && occ_ff != '0) + 1'b1;
               end else if (!hit) begin
                  status_in = ST_MISS;
               end else if (refs_ff[cmp_idx_ff] == '1) begin
                  status_in = ST_ERR;
               end else begin
                  refs_in[cmp_idx_ff] = refs_ff[cmp_idx_ff] + 1'b1;
                  status_in   = ST_OK;
                  slot_res_in = SLOT_W'(cmp_idx_ff);
               end
            end else begin
               mem_re     = 1'b1;
               mem_raddr  = rd_idx_ff[SW-1:0];
               cmp_idx_in = rd_idx_ff[SW-1:0];
               cmp_vld_in = 1'b1;
               rd_idx_in  = rd_idx_ff + 1'b1;
            end
         end
         S_NOTICE: begin
            if (buf_free) begin
               rsp_push             = 1'b1;
               rsp_beat.kind        = KIND_NOTICE;
               rsp_beat.status      = ST_OK;
               rsp_beat.freed_value = mem_rvalue;
               state_in             = ret_ff;
            end
         end
         S_ANSWER: begin
            if (buf_free) begin
               rsp_push          = 1'b1;
               rsp_beat.kind     = KIND_ANSWER;
               rsp_beat.status   = status_ff;
               rsp_beat.slot_res = slot_res_ff;
               rsp_beat.last     = 1'b1;
               state_in          = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // push the freed slot on the free stack
      if (freeing && fdepth_ff < CW'(ENTRIES)) begin
         fstack_in[fdepth_ff[SW-1:0]] = mem_raddr;
         fdepth_in = fdepth_ff + 1'b1;
      end

      // end of a clock sweep
      if (fin) begin
         if (op_ff == OP_TRIM) begin
            status_in = fin_ok ? ST_OK : ST_MISS;
            state_in  = S_ANSWER;
         end else if (fin_ok) begin
            state_in = S_ALLOC;
         end else begin
            status_in = ST_MISS;
            state_in  = S_ANSWER;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_IDLE;
         created_ff <= '0;
         fdepth_ff  <= '0;
         hand_ff    <= '0;
         occ_ff     <= '0;
         cap_ff     <= CAP_RESET;
         second_ff  <= 1'b0;
         cmp_vld_ff <= 1'b0;
         rd_idx_ff  <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            in_cache_ff[i] <= 1'b0;
            used_ff[i]     <= 1'b0;
            refs_ff[i]     <= '0;
         end
      end else begin
         state_ff    <= state_in;
         ret_ff      <= ret_in;
         created_ff  <= created_in;
         fdepth_ff   <= fdepth_in;
         hand_ff     <= hand_in;
         occ_ff      <= occ_in;
         cap_ff      <= cap_in;
         second_ff   <= second_in;
         cmp_vld_ff  <= cmp_vld_in;
         rd_idx_ff   <= rd_idx_in;
         in_cache_ff <= in_cache_in;
         used_ff     <= used_in;
         refs_ff     <= refs_in;
      end
      fstack_ff   <= fstack_in;
      start_ff    <= start_in;
      pos_ff      <= pos_in;
      cmp_idx_ff  <= cmp_idx_in;
      new_slot_ff <= new_slot_in;
      status_ff   <= status_in;
      slot_res_ff <= slot_res_in;
      if (req_ch.valid && req_ch.ready) begin
         op_ff        <= req_ch.op;
         key_ff       <= req_ch.key;
         value_ff     <= req_ch.value;
         hold_ff      <= req_ch.hold_ref;
         rel_slot_ff  <= req_ch.slot;
         set_usage_ff <= req_ch.set_usage;
      end
   end

   // every created slot is either occupied or on the free stack
   `CCRD_ASSERT_IMPL(a_slot_books, clock, reset, state_ff == S_IDLE, (7'(occ_ff) + 7'(fdepth_ff)) == 7'(created_ff), "occupancy plus free depth differs from created slots")
   `CCRD_ASSERT_IMPL(a_push_room, clock, reset, rsp_push, buf_free, "response pushed into a full output register")
   `CCRD_ASSERT_NEXT(a_notice_out, clock, reset, state_ff == S_NOTICE && buf_free, rsp_ch.valid && rsp_ch.kind == KIND_NOTICE, "freed notice not presented")
endmodule

### hw/rtl/ccrd_kv_mem.sv
// Key and value store: one write port, one registered read port.
// Depends on ccrd_pkg.
`timescale 1ns / 1ps
module ccrd_kv_mem #(
   parameter int ENTRIES = 32,
   parameter int SW      = 5
) (
   input  logic                       clock,
   input  logic                       we,
   input  logic [SW-1:0]              waddr,
   input  logic [ccrd_pkg::KEY_W-1:0] wkey,
   input  logic [ccrd_pkg::VAL_W-1:0] wvalue,
   input  logic                       re,
   input  logic [SW-1:0]              raddr,
   output logic [ccrd_pkg::KEY_W-1:0] rkey,
   output logic [ccrd_pkg::VAL_W-1:0] rvalue
);
   import ccrd_pkg::*;

   logic [KEY_W-1:0] key_mem [ENTRIES];
   logic [VAL_W-1:0] val_mem [ENTRIES];
   logic [KEY_W-1:0] rkey_ff;
   logic [VAL_W-1:0] rvalue_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         key_mem[waddr] <= wkey;
         val_mem[waddr] <= wvalue;
      end
      if (re) begin
         rkey_ff   <= key_mem[raddr];
         rvalue_ff <= val_mem[raddr];
      end
   end

   assign rkey   = rkey_ff;
   assign rvalue = rvalue_ff;
endmodule

### hw/rtl/ccrd_rsp_reg.sv
// Output register of the response channel.
// Depends on ccrd_pkg and ccrd_rsp_if.
`timescale 1ns / 1ps
module ccrd_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ccrd_pkg::rsp_beat_type beat,
   output logic                   can_take,
   ccrd_rsp_if.source             rsp_ch
);
   import ccrd_pkg::*;

   logic         valid_ff;
   rsp_beat_type beat_ff;

   assign can_take = !valid_ff || rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (can_take) begin
         valid_ff <= push;
      end
      if (push && can_take) begin
         beat_ff <= beat;
      end
   end

   assign rsp_ch.valid       = valid_ff;
   assign rsp_ch.kind        = beat_ff.kind;
   assign rsp_ch.status      = beat_ff.status;
   assign rsp_ch.slot_res    = beat_ff.slot_res;
   assign rsp_ch.freed_value = beat_ff.freed_value;
   assign rsp_ch.last        = beat_ff.last;
endmodule

### tb/clock_cache_refcount_directory_tb.sv
// Self-checking testbench for clock_cache_refcount_directory.
// Uses ccrd_pkg and the ccrd_req_if / ccrd_rsp_if channels from the RTL.
// A model of the clock directory predicts every response beat.
`timescale 1ns / 1ps
module clock_cache_refcount_directory_tb;
   import ccrd_pkg::*;

   localparam int ENTRIES = 32;
   localparam int REF_MAX = 65535;
   localparam int SETTLE  = 150;   // cycles after the last answer before a csr write

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CAP_W-1:0] csr_wdata = '0;

   ccrd_req_if req_ch ();
   ccrd_rsp_if rsp_ch ();

   clock_cache_refcount_directory dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Directory model: mirrors slot flags, counts, free stack and hand
   // ---------------------------------------------------------------
   logic [KEY_W-1:0] m_key [ENTRIES];
   logic [VAL_W-1:0] m_val [ENTRIES];
   bit               m_inc [ENTRIES];
   bit               m_used[ENTRIES];
   int               m_refs[ENTRIES];
   int               m_free[ENTRIES];
   int               m_created, m_depth, m_hand, m_occ, m_cap;

   rsp_beat_type pending_beats[$];   // responses still owed by the DUT
   int           errors;
   bit           quiet;              // no idling on either side

   function automatic void push_beat(logic kind, logic [1:0] st, int sl,
                                     logic [VAL_W-1:0] fv, logic lst);
      rsp_beat_type b;
      b.kind = kind; b.status = st; b.slot_res = sl[SLOT_W-1:0];
      b.freed_value = fv; b.last = lst;
      pending_beats = {pending_beats, b};
   endfunction

   function automatic void release_slot(int i);
      push_beat(KIND_NOTICE, ST_OK, 0, m_val[i], 1'b0);
      if (m_depth < ENTRIES) begin
         m_free[m_depth] = i;
         m_depth++;
      end
      if (m_occ > 0) m_occ--;
   endfunction

   // Second-chance sweep; returns 0 when two idle laps pass without room
   function automatic bit clock_sweep();
      int start, pos;
      bit lap2, evicted;
      if (m_occ == 0 || m_created == 0) return 1'b1;
      start = (m_hand < m_created) ? m_hand : 0;
      pos = start;
      lap2 = 1'b0;
      while (m_occ >= m_cap) begin
         evicted = 1'b0;
         if (m_inc[pos] && !m_used[pos] && m_refs[pos] == 0) begin
            m_inc[pos] = 1'b0;
            release_slot(pos);
            evicted = 1'b1;
         end else begin
            m_used[pos] = 1'b0;
         end
         pos = (pos + 1 >= m_created) ? 0 : pos + 1;
         if (!evicted && pos == start) begin
            if (lap2) return 1'b0;
            lap2 = 1'b1;
         end
      end
      m_hand = pos;
      return 1'b1;
   endfunction

   function automatic int find_entry(logic [KEY_W-1:0] k, int skip);
      for (int i = 0; i < m_created; i++)
         if (i != skip && m_inc[i] && m_key[i] == k) return i;
      return -1;
   endfunction

   // Work out all beats caused by one accepted request
   function automatic void predict_op(logic [1:0] op, logic [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v, bit hold, int sl, bit usage);
      int s, old;
      case (op)
         OP_INSERT: begin
            if (!clock_sweep()) begin
               push_beat(KIND_ANSWER, ST_MISS, 0, '0, 1'b1);
               return;
            end
            if (m_depth > 0) begin
               m_depth--;
               s = m_free[m_depth];
            end else if (m_created < ENTRIES) begin
               s = m_created;
               m_created++;
            end else begin
               push_beat(KIND_ANSWER, ST_MISS, 0, '0, 1'b1);
               return;
            end
            m_key[s] = k; m_val[s] = v; m_inc[s] = 1'b1; m_used[s] = 1'b0;
            m_refs[s] = hold ? 1 : 0;
            old = find_entry(k, s);
            if (old >= 0) begin
               m_inc[old] = 1'b0;
               if (m_refs[old] == 0) release_slot(old);
            end
            m_occ = (m_occ + 1) & 63;
            push_beat(KIND_ANSWER, ST_OK, s, '0, 1'b1);
         end
         OP_LOOKUP: begin
            s = find_entry(k, ENTRIES);
            if (s < 0) push_beat(KIND_ANSWER, ST_MISS, 0, '0, 1'b1);
            else if (m_refs[s] >= REF_MAX) push_beat(KIND_ANSWER, ST_ERR, 0, '0, 1'b1);
            else begin
               m_refs[s]++;
               push_beat(KIND_ANSWER, ST_OK, s, '0, 1'b1);
            end
         end
         OP_RELEASE: begin
            if (m_refs[sl] == 0) begin
               push_beat(KIND_ANSWER, ST_ERR, 0, '0, 1'b1);
               return;
            end
            if (usage) m_used[sl] = 1'b1;
            m_refs[sl]--;
            if (m_refs[sl] == 0 && !m_inc[sl]) release_slot(sl);
            push_beat(KIND_ANSWER, ST_OK, 0, '0, 1'b1);
         end
         default: begin
            if (clock_sweep()) push_beat(KIND_ANSWER, ST_OK, 0, '0, 1'b1);
            else push_beat(KIND_ANSWER, ST_MISS, 0, '0, 1'b1);
         end
      endcase
   endfunction

   // Half the time zero, often short, now and then long
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(40, 20);
   endfunction

   // ---------------------------------------------------------------
   // Response side: random ready, compare each beat in order
   // ---------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_beats.size() == 0) begin
               $error("unexpected response beat kind=%0d status=%0d",
                      rsp_ch.kind, rsp_ch.status);
               errors++;
            end else begin
               rsp_beat_type e;
               e = pending_beats.pop_front();
               if (rsp_ch.kind !== e.kind) begin
                  $error("kind: expected %0d, got %0d", e.kind, rsp_ch.kind); errors++;
               end
               if (rsp_ch.status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_ch.status); errors++;
               end
               if (rsp_ch.slot_res !== e.slot_res) begin
                  $error("slot_res: expected %0d, got %0d", e.slot_res, rsp_ch.slot_res);
                  errors++;
               end
               if (rsp_ch.freed_value !== e.freed_value) begin
                  $error("freed_value: expected %h, got %h", e.freed_value,
                         rsp_ch.freed_value);
                  errors++;
               end
               if (rsp_ch.last !== e.last) begin
                  $error("last: expected %0d, got %0d", e.last, rsp_ch.last); errors++;
               end
            end
         end
         // stall the receiver at random; hold ready high through quiet stretches
         if (quiet || $urandom_range(99) < 60) rsp_ch.ready <= 1'b1;
         else rsp_ch.ready <= 1'b0;
      end
   end

   // ---------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------
   // Present one request, hold it until accepted, then predict its beats.
   task automatic send_req(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                           bit hold, int sl, bit usage);
      int gap;
      req_ch.valid <= 1'b1;
      req_ch.op <= op; req_ch.key <= k; req_ch.value <= v;
      req_ch.hold_ref <= hold; req_ch.slot <= sl[SLOT_W-1:0]; req_ch.set_usage <= usage;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_op(op, k, v, hold, sl, usage);
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_beats.size() != 0) @(posedge clock);
   endtask

   // Capacity changes only while idle.
   task automatic set_capacity(int c);
      wait_drained();
      repeat (SETTLE) @(posedge clock);
      csr_we <= 1'b1;
      csr_wdata <= c[CAP_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      m_cap = c;
   endtask

   typedef struct {
      logic [1:0]       op;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      bit               hold;
      int               sl;
      bit               usage;
      bit               typed;   // final answer typed in below
      logic [1:0]       st;
      int               sres;
   } stim_row_type;

   localparam logic [63:0] ONES = '1;

   // Directed rows, starting from the reset state with capacity 32
   stim_row_type directed[] = '{
      '{OP_RELEASE, 64'd0, 64'd0, 0, 0,  0, 1, ST_ERR,  0},  // release of an unused slot
      '{OP_LOOKUP,  64'd0, 64'd0, 0, 0,  0, 1, ST_MISS, 0},  // lookup on an empty directory
      '{OP_INSERT,  ONES,  ONES,  1, 0,  0, 1, ST_OK,   0},  // max key/value, held
      '{OP_LOOKUP,  ONES,  64'd0, 0, 0,  0, 1, ST_OK,   0},
      '{OP_RELEASE, 64'd0, 64'd0, 0, 0,  1, 1, ST_OK,   0},  // release + usage mark
      '{OP_RELEASE, 64'd0, 64'd0, 0, 0,  0, 1, ST_OK,   0},
      '{OP_RELEASE, 64'd0, 64'd0, 0, 0,  0, 1, ST_ERR,  0},  // count underflow
      '{OP_RELEASE, 64'd0, 64'd0, 0, 31, 1, 1, ST_ERR,  0},  // top slot index
      '{OP_INSERT,  64'd0, 64'd0, 0, 0,  0, 1, ST_OK,   1},  // zero key/value
      '{OP_INSERT,  64'd0, 64'h5555_5555_5555_5555, 1, 0, 0, 0, ST_OK, 0}, // displaces slot 1
      '{OP_LOOKUP,  64'd0, 64'd0, 0, 0,  0, 0, ST_OK,   0},
      '{OP_INSERT,  64'd1, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, 0, 0, ST_OK, 0}, // reuses freed slot
      '{OP_RELEASE, 64'd0, 64'd0, 0, 2,  0, 0, ST_OK,   0},
      '{OP_TRIM,    64'd0, 64'd0, 0, 0,  0, 1, ST_OK,   0}
   };

   logic [KEY_W-1:0] key_pool[8];

   task automatic random_item();
      int r, s, pick;
      logic [KEY_W-1:0] k;
      logic [VAL_W-1:0] v;
      r = $urandom_range(99);
      k = ($urandom_range(99) < 75) ? key_pool[$urandom_range(7)] : {$urandom, $urandom};
      v = {$urandom, $urandom};
      if (r < 38) begin
         send_req(OP_INSERT, k, v, $urandom_range(1), $urandom_range(31), $urandom_range(1));
      end else if (r < 62) begin
         send_req(OP_LOOKUP, k, v, $urandom_range(1), $urandom_range(31), $urandom_range(1));
      end else if (r < 90) begin
         // usually release a slot that holds a reference
         s = $urandom_range(31);
         if ($urandom_range(99) < 80) begin
            pick = $urandom_range(31);
            for (int i = 0; i < ENTRIES; i++)
               if (m_refs[(pick + i) % ENTRIES] > 0) begin
                  s = (pick + i) % ENTRIES;
                  break;
               end
         end
         send_req(OP_RELEASE, k, v, $urandom_range(1), s, $urandom_range(1));
      end else begin
         send_req(OP_TRIM, k, v, $urandom_range(1), $urandom_range(31), $urandom_range(1));
      end
   endtask

   int caps[] = '{4, 1, 63, 0, 8, 2, 32, 17, 33};

   initial begin
      req_ch.valid = 1'b0;
      req_ch.op = OP_INSERT; req_ch.key = '0; req_ch.value = '0;
      req_ch.hold_ref = 1'b0; req_ch.slot = '0; req_ch.set_usage = 1'b0;
      errors = 0;
      quiet = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         m_key[i] = '0; m_val[i] = '0; m_inc[i] = 0; m_used[i] = 0;
         m_refs[i] = 0; m_free[i] = 0;
      end
      m_created = 0; m_depth = 0; m_hand = 0; m_occ = 0; m_cap = 32;
      for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
      key_pool[0] = '0;
      key_pool[1] = ONES;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows overwrite the model's final answer
      foreach (directed[i]) begin
         send_req(directed[i].op, directed[i].k, directed[i].v, directed[i].hold,
                  directed[i].sl, directed[i].usage);
         if (directed[i].typed) begin
            pending_beats[$].status   = directed[i].st;
            pending_beats[$].slot_res = directed[i].sres[SLOT_W-1:0];
         end
      end

      // capacity one forces evictions; capacity zero makes every sweep over a non-empty directory fail
      set_capacity(1);
      send_req(OP_TRIM, '0, '0, 0, 0, 0);
      send_req(OP_INSERT, 64'd7, {$urandom, $urandom}, 0, 0, 0);
      send_req(OP_INSERT, 64'd8, {$urandom, $urandom}, 1, 0, 0);
      set_capacity(0);
      send_req(OP_TRIM, '0, '0, 0, 0, 0);
      send_req(OP_INSERT, 64'd9, {$urandom, $urandom}, 0, 0, 0);

      // random phases over several capacities, extremes included
      foreach (caps[p]) begin
         set_capacity(caps[p]);
         for (int n = 0; n < 36; n++) begin
            if (n == 18 && p == 2) wait_drained();   // sender holds off until all answers are in
            quiet = (n >= 28 && p % 3 == 0);
            random_item();
         end
         quiet = 1'b0;
      end

      wait_drained();
      repeat (SETTLE) @(posedge clock);
      if (errors == 0 && pending_beats.size() == 0) $display("SCOREBOARD CLEAN");
      else $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // watchdog: far beyond the longest sweeps and receiver stalls
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end
endmodule
